[rtl/core/cld_pkg.sv]
package cld_pkg;

    localparam int TIME_W   = 63;
    localparam int WIN_W    = 32;
    localparam int THR_W    = 6;
    localparam int OWNER_W  = 32;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [WIN_W-1:0] WINDOW_RST    = 32'd600000;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 6'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_EXIT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_APPEND,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd;
        logic append;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic rd_done;
        logic out_free;
    } t_status;

endpackage

[rtl/core/cld_ram.sv]
module cld_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/cld_ctrl.sv]
module cld_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  cld_pkg::t_status i_status,
    output cld_pkg::t_cmd    o_cmd,
    output logic             o_in_stall
);

    import cld_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_func == FUNC_EXIT) ? ST_RESULT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.rd_done) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.load  = i_in_valid && (i_func == FUNC_START);
                o_cmd.clear = i_in_valid && (i_func == FUNC_EXIT);
            end
            ST_WALK:   o_cmd.rd     = !i_status.rd_done;
            ST_APPEND: o_cmd.append = 1'b1;
            ST_RESULT: o_cmd.finish = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/core/cld_dp.sv]
module cld_dp #(
    parameter int MAX_CRASHES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [cld_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cld_pkg::WIN_W-1:0]      i_cfg_data,
    input  logic [cld_pkg::TIME_W-1:0]     i_now_ms,
    input  cld_pkg::t_cmd                  i_cmd,
    output cld_pkg::t_status               o_status,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_previous_crashed,
    output logic [cld_pkg::CNT_W-1:0]      o_crash_cnt,
    output logic                           o_loop_found
);

    import cld_pkg::*;

    localparam int AW = (MAX_CRASHES > 1) ? $clog2(MAX_CRASHES) : 1;
    localparam int CW = $clog2(MAX_CRASHES + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(MAX_CRASHES - 1);
    localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_CRASHES);

    logic [WIN_W-1:0]  r_window;
    logic [THR_W-1:0]  r_threshold;
    logic [CW-1:0]     r_count;
    logic              r_running;
    logic              r_crashed;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW-1:0]     r_wr_ptr;
    logic [CW-1:0]     r_rd_idx;
    logic [CW-1:0]     r_n;
    logic              r_chk;
    logic [TIME_W-1:0] r_now;
    logic signed [TIME_W:0] r_wstart;
    logic              r_out_valid;
    logic              r_prev;
    logic [CNT_W-1:0]  r_recent;
    logic              r_loop;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic [TIME_W-1:0] rd_data;
    logic              keep;
    logic              loop_hit;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    cld_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_CRASHES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_data)
    );

    // window test: wstart < t <= now, wstart may be negative
    assign keep = ($signed({1'b0, rd_data}) > r_wstart) && (rd_data <= r_now);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_ptr;
        wr_data = rd_data;
        if (i_cmd.append && r_crashed) begin
            wr_en   = 1'b1;
            wr_data = r_now;
        end else if (r_chk && keep) begin
            wr_en = 1'b1;
        end
    end

    assign loop_hit = r_crashed && (32'(r_count) >= 32'(r_threshold));

    assign o_status.rd_done  = (r_rd_idx == r_count);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now    <= i_now_ms;
            r_wstart <= $signed({1'b0, i_now_ms}) - $signed({1'b0, 31'd0, r_window});
        end
        if (i_cmd.finish) begin
            r_prev   <= r_crashed;
            r_recent <= CNT_W'(r_count);
            r_loop   <= loop_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RST;
            r_threshold <= THRESHOLD_RST;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_crashed   <= 1'b0;
            r_head      <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_rd_idx    <= '0;
            r_n         <= '0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WINDOW:    r_window    <= i_cfg_data;
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end

            r_chk <= i_cmd.rd;

            if (i_cmd.load) begin
                r_crashed <= r_running;
                r_rd_ptr  <= r_head;
                r_wr_ptr  <= r_head;
                r_rd_idx  <= '0;
                r_n       <= '0;
            end

            if (i_cmd.clear) begin
                r_crashed <= 1'b0;
                r_running <= 1'b0;
                r_count   <= '0;
            end

            if (i_cmd.rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
                r_rd_idx <= r_rd_idx + 1'b1;
            end

            if (r_chk && keep) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
                r_n      <= r_n + 1'b1;
            end

            if (i_cmd.append) begin
                r_running <= 1'b1;
                if (r_crashed) begin
                    if (r_n == MAX_CNT) begin
                        // ring full: newest overwrites oldest
                        r_head  <= ptr_inc(r_head);
                        r_count <= MAX_CNT;
                    end else begin
                        r_count <= r_n + 1'b1;
                    end
                end else begin
                    r_count <= r_n;
                end
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_previous_crashed = r_prev;
    assign o_crash_cnt        = r_recent;
    assign o_loop_found       = r_loop;

endmodule

[rtl/core/crash_loop_window_detector_core.sv]
// Crash-loop window detector.
// Input channel (i_in_valid / o_in_stall): one beat per event. i_func = start
// carries i_now_ms and i_owner_id; i_func = clean exit clears the history.
// Output channel (o_out_valid / i_out_stall): exactly one result beat per
// input beat, in order: previous_crashed, crash_cnt, loop_found.
// Config channel (i_cfg_valid / o_cfg_ready, ready always high): index 0 is
// the window in ms, index 1 the crash threshold. Write only while idle.
// Sequence: a start beat walks the stored crash times once, one memory read
// per cycle. With count crash times held (at most MAX_CRASHES), each is read
// and checked against the window, the new crash time is appended if the last
// run crashed, and the result is registered before the next input beat is
// taken. A clean exit skips the walk and goes straight to the result state.
// A result is held in an output register; the next input beat is accepted
// while it waits, but a new result is not produced until the held one is
// taken, so a stalled receiver backs up the input channel after one event.
// Reset (synchronous, active low) clears the history, the running flag and
// the output valid, and restores the register defaults (600000 ms, 3).
module crash_loop_window_detector_core #(
    parameter int MAX_CRASHES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cld_pkg::WIN_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [cld_pkg::TIME_W-1:0]    i_now_ms,
    input  logic [cld_pkg::OWNER_W-1:0]   i_owner_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_previous_crashed,
    output logic [cld_pkg::CNT_W-1:0]     o_crash_cnt,
    output logic                          o_loop_found
);

    import cld_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    cld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    cld_dp #(
        .MAX_CRASHES (MAX_CRASHES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_now_ms           (i_now_ms),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_previous_crashed (o_previous_crashed),
        .o_crash_cnt        (o_crash_cnt),
        .o_loop_found       (o_loop_found)
    );

endmodule

[rtl/core/cld_chk.sv]
module cld_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_previous_crashed,
    input logic [cld_pkg::CNT_W-1:0]     o_crash_cnt,
    input logic                          o_loop_found
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_previous_crashed)
            && $stable(o_crash_cnt) && $stable(o_loop_found))
        else $error("stalled result beat changed");

    a_loop_needs_crash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_loop_found |-> o_previous_crashed)
        else $error("crash loop without previous crash");

    a_crash_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_previous_crashed |-> o_crash_cnt != '0)
        else $error("previous crash not counted");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while event in progress");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind crash_loop_window_detector_core cld_chk u_cld_chk (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import cld_pkg::*;

    localparam int CAP         = 32;
    localparam int DRAIN_GAP   = 40;
    localparam int STUCK_LIMIT = 5000;
    localparam int PHASE_BEATS = 230;
    localparam logic [63:0] TMAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic                 func;
        logic [TIME_W-1:0]    now;
        logic [OWNER_W-1:0]   owner;
    } t_event;

    typedef struct {
        logic                 prev_crashed;
        logic [CNT_W-1:0]     recent;
        logic                 loop;
    } t_report;

    typedef struct {
        bit                   typed;
        t_report              want;
    } t_note;

    typedef enum {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        t_event               ev;
        bit                   typed;
        t_report              want;
        logic [CFG_IDX_W-1:0] idx;
        logic [WIN_W-1:0]     data;
    } t_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [WIN_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_func      = 1'b0;
    logic [TIME_W-1:0]    i_now_ms    = '0;
    logic [OWNER_W-1:0]   i_owner_id  = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_previous_crashed;
    logic [CNT_W-1:0]     o_crash_cnt;
    logic                 o_loop_found;

    crash_loop_window_detector_core dut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [TIME_W-1:0]  crash_hist [CAP];
    int                 hist_len   = 0;
    bit                 running    = 1'b0;
    logic [OWNER_W-1:0] owner_q    = '0;
    logic [WIN_W-1:0]   win_ms     = WINDOW_RST;
    logic [THR_W-1:0]   loop_thr   = THRESHOLD_RST;

    t_report pending_reports [$];
    t_note   report_notes [$];
    t_row    dir_rows [$];
    int      n_fail      = 0;
    int      beats_sent  = 0;
    int      src_pct     = 0;
    int      sink_pct    = 0;
    int      hold_left   = 0;
    int      stuck_cycles = 0;

    task automatic eval_event(input t_event ev, output t_report rep);
        logic [TIME_W-1:0] kept [CAP+1];
        int                n;
        int                drop;
        longint            now_s;
        longint            wstart;
        longint            at;
        bit                crashed;
        if (ev.func == FUNC_EXIT) begin
            hist_len = 0;
            running  = 1'b0;
            owner_q  = '0;
            rep = '{1'b0, '0, 1'b0};
        end else begin
            now_s   = longint'({1'b0, ev.now});
            wstart  = now_s - longint'({32'd0, win_ms});
            crashed = running;
            n = 0;
            for (int i = 0; i < hist_len; i++) begin
                at = longint'({1'b0, crash_hist[i]});
                if (at > wstart && at <= now_s) begin
                    kept[n] = crash_hist[i];
                    n++;
                end
            end
            if (crashed) begin
                kept[n] = ev.now;
                n++;
            end
            drop = (n > CAP) ? n - CAP : 0;
            for (int i = 0; i + drop < n; i++)
                crash_hist[i] = kept[i + drop];
            hist_len = n - drop;
            running  = 1'b1;
            owner_q  = ev.owner;
            rep.prev_crashed = crashed;
            rep.recent       = CNT_W'(hist_len);
            rep.loop         = crashed && (hist_len >= int'(loop_thr));
        end
    endtask

    // beat monitor and scoreboard
    always @(posedge i_clk) begin
        t_report pred;
        t_report want;
        t_note   note;
        t_event  ev;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_WINDOW)
                    win_ms = i_cfg_data;
                else if (i_cfg_index == CFG_THRESHOLD)
                    loop_thr = i_cfg_data[THR_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                ev = '{i_func, i_now_ms, i_owner_id};
                eval_event(ev, pred);
                note = report_notes.pop_front();
                pending_reports.insert(pending_reports.size(), note.typed ? note.want : pred);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result beat");
                    n_fail++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_previous_crashed !== want.prev_crashed) begin
                        $error("previous_crashed: expected %0d, got %0d",
                               want.prev_crashed, o_previous_crashed);
                        n_fail++;
                    end
                    if (o_crash_cnt !== want.recent) begin
                        $error("crash_cnt: expected %0d, got %0d",
                               want.recent, o_crash_cnt);
                        n_fail++;
                    end
                    if (o_loop_found !== want.loop) begin
                        $error("loop_found: expected %0d, got %0d",
                               want.loop, o_loop_found);
                        n_fail++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < sink_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic t_event mk_event(logic f, logic [TIME_W-1:0] now,
                                        logic [OWNER_W-1:0] own);
        t_event ev;
        ev.func  = f;
        ev.now   = now;
        ev.owner = own;
        return ev;
    endfunction

    function automatic t_row beat_row(logic f, logic [TIME_W-1:0] now,
                                      logic [OWNER_W-1:0] own, bit typed,
                                      logic pc, logic [CNT_W-1:0] cnt, logic lp);
        t_row r;
        r.kind  = ROW_BEAT;
        r.ev    = mk_event(f, now, own);
        r.typed = typed;
        r.want  = '{pc, cnt, lp};
        r.idx   = '0;
        r.data  = '0;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
        t_row r;
        r.kind  = ROW_CFG;
        r.ev    = mk_event(FUNC_START, '0, '0);
        r.typed = 1'b0;
        r.want  = '{1'b0, '0, 1'b0};
        r.idx   = idx;
        r.data  = data;
        return r;
    endfunction

    task automatic add_row(input t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic offer(input t_event ev, input bit typed, input t_report want);
        t_note note;
        while ($urandom_range(99) < src_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        note.typed = typed;
        note.want  = want;
        report_notes.insert(report_notes.size(), note);
        i_in_valid <= 1'b1;
        i_func     <= ev.func;
        i_now_ms   <= ev.now;
        i_owner_id <= ev.owner;
        beats_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_phase(input logic [WIN_W-1:0] win, input logic [THR_W-1:0] thr,
                             input int s_pct, input int k_pct);
        settle();
        cfg_write(CFG_WINDOW, win);
        cfg_write(CFG_THRESHOLD, WIN_W'(thr));
        src_pct  = s_pct;
        sink_pct = k_pct;
    endtask

    // mostly runs of starts with gaps scaled to the window, some noise
    task automatic run_phase(input int quota);
        t_report     none;
        logic [63:0] t;
        logic [63:0] win64;
        int          stop;
        int          len;
        int          shift;
        int          sel;
        none  = '{1'b0, '0, 1'b0};
        stop  = beats_sent + quota;
        win64 = {32'd0, win_ms};
        while (beats_sent < stop) begin
            if ($urandom_range(99) < 80) begin
                case ($urandom_range(3))
                    0: t = 64'($urandom_range(2000));
                    1: t = {$urandom, $urandom} & TMAX;
                    2: t = TMAX - 64'($urandom_range(100000));
                    default: t = 64'd600000 + 64'($urandom);
                endcase
                shift = $urandom_range(9, 2);
                len   = $urandom_range(45, 1);
                if ($urandom_range(1) == 1)
                    offer(mk_event(FUNC_EXIT, '0, '0), 1'b0, none);
                for (int k = 0; k < len && beats_sent < stop; k++) begin
                    offer(mk_event(FUNC_START, t[TIME_W-1:0], $urandom), 1'b0, none);
                    sel = $urandom_range(99);
                    if (sel < 70)
                        t = t + 64'($urandom_range(32'((win64 >> shift) + 64'd1)));
                    else if (sel < 85)
                        t = t;
                    else if (sel < 95)
                        t = t + win64 + 64'($urandom_range(2))
                            - ((win64 != 64'd0) ? 64'd1 : 64'd0);
                    else if (t > 64'd1000)
                        t = t - 64'($urandom_range(1000, 1));
                    t = t & TMAX;
                end
            end else begin
                if ($urandom_range(1) == 1)
                    t = {$urandom, $urandom} & TMAX;
                else
                    t = 64'($urandom_range(5000));
                offer(mk_event(1'($urandom_range(1)), t[TIME_W-1:0], $urandom), 1'b0, none);
            end
        end
    endtask

    initial begin
        t_report     none;
        logic [63:0] t;
        none = '{1'b0, '0, 1'b0};

        add_row(beat_row(FUNC_START, 63'd1000, 32'd0, 1, 0, 0, 0));
        add_row(beat_row(FUNC_START, 63'd2000, 32'd1, 1, 1, 1, 0));
        add_row(beat_row(FUNC_START, 63'd3000, 32'd2, 1, 1, 2, 0));
        add_row(beat_row(FUNC_START, 63'd4000, 32'd3, 1, 1, 3, 1));
        add_row(beat_row(FUNC_EXIT, '1, '1, 1, 0, 0, 0));
        add_row(beat_row(FUNC_START, 63'd0, '1, 1, 0, 0, 0));
        add_row(beat_row(FUNC_START, 63'd0, 32'd7, 1, 1, 1, 0));
        add_row(beat_row(FUNC_START, '1, 32'd8, 1, 1, 1, 0));
        // stored time ahead of now is dropped
        add_row(beat_row(FUNC_START, 63'd5, 32'd9, 1, 1, 1, 0));
        // window start is exclusive
        add_row(beat_row(FUNC_START, 63'd600005, 32'd10, 1, 1, 1, 0));
        add_row(beat_row(FUNC_START, 63'd1200004, 32'd11, 1, 1, 2, 0));
        add_row(beat_row(FUNC_EXIT, 63'd77, 32'd12, 1, 0, 0, 0));
        add_row(cfg_row(CFG_THRESHOLD, 32'd0));
        add_row(cfg_row(CFG_WINDOW, 32'd0));
        add_row(beat_row(FUNC_START, 63'd100, 32'd13, 1, 0, 0, 0));
        add_row(beat_row(FUNC_START, 63'd100, 32'd14, 1, 1, 1, 1));
        add_row(beat_row(FUNC_START, 63'd100, 32'd15, 1, 1, 1, 1));
        add_row(cfg_row(CFG_WINDOW, 32'hFFFF_FFFF));
        add_row(cfg_row(CFG_THRESHOLD, 32'd63));
        add_row(beat_row(FUNC_START, 63'd10, 32'd16, 1, 1, 1, 0));
        add_row(beat_row(FUNC_START, 63'd20, 32'd17, 0, 0, 0, 0));
        add_row(cfg_row(CFG_WINDOW, 32'd1));
        add_row(cfg_row(CFG_THRESHOLD, 32'd1));
        add_row(beat_row(FUNC_START, 63'd21, 32'd18, 1, 1, 1, 1));
        add_row(beat_row(FUNC_START, 63'd22, 32'h5A5A_A5A5, 0, 0, 0, 0));
        add_row(beat_row(FUNC_EXIT, 63'd0, 32'd0, 1, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                offer(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        // long receiver hold-off while starts keep coming
        set_phase(32'd600000, 6'd3, 0, 0);
        hold_left = 400;
        t = 64'd5000;
        for (int k = 0; k < 24; k++) begin
            offer(mk_event(FUNC_START, t[TIME_W-1:0], $urandom), 1'b0, none);
            t = t + 64'd1000;
        end
        settle();

        set_phase(32'd600000, 6'd3, 0, 0);
        run_phase(PHASE_BEATS);
        set_phase(32'd1000, 6'd5, 47, 0);
        run_phase(PHASE_BEATS);
        set_phase(32'hFFFF_FFFF, 6'd33, 0, 47);
        run_phase(PHASE_BEATS);
        set_phase(32'd50, 6'd1, 23, 23);
        run_phase(PHASE_BEATS);
        set_phase(32'd0, 6'd0, 47, 0);
        run_phase(PHASE_BEATS);
        set_phase(32'd1, 6'd63, 0, 47);
        run_phase(PHASE_BEATS);
        set_phase($urandom_range(5000, 1), THR_W'($urandom_range(33, 1)), 23, 23);
        run_phase(PHASE_BEATS);
        set_phase(32'd100000, 6'd2, 0, 0);
        run_phase(PHASE_BEATS);

        settle();
        if (n_fail == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
